[rtl/core/tvs_pkg.sv]
// Shared types, constants and trig table for the turtle vector stepper.
package tvs_pkg;

   localparam int unsigned POS_W     = 24;
   localparam int unsigned HEADING_W = 9;
   localparam int unsigned AMOUNT_W  = 16;
   localparam int unsigned HOME_W    = 10;
   localparam int unsigned SINE_W    = 17;
   localparam int unsigned WIDE_W    = 36;

   localparam logic [1:0] OP_MOVE = 2'd0;
   localparam logic [1:0] OP_TURN = 2'd1;
   localparam logic [1:0] OP_HOME = 2'd2;
   localparam logic [1:0] OP_PEN  = 2'd3;

   localparam logic CSR_HOME_X = 1'b0;
   localparam logic CSR_HOME_Y = 1'b1;

   localparam logic [HOME_W-1:0]    HOME_X_RESET  = 10'd160;
   localparam logic [HOME_W-1:0]    HOME_Y_RESET  = 10'd90;
   localparam logic [HEADING_W-1:0] HOME_HEADING  = 9'd90;
   localparam logic [HEADING_W-1:0] QUARTER_TURN  = 9'd90;
   localparam logic [HEADING_W-1:0] HALF_TURN     = 9'd180;
   localparam logic [HEADING_W-1:0] THREE_QUARTER = 9'd270;
   localparam logic [HEADING_W:0]   FULL_TURN     = 10'd360;

   localparam logic signed [POS_W-1:0]  POS_MAX  = 24'sh7FFFFF;
   localparam logic signed [POS_W-1:0]  POS_MIN  = -24'sh800000;
   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 36'sd8388607;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -36'sd8388608;

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [AMOUNT_W-1:0] amount;
      logic                       pen_down;
   } tvs_req_type;

   typedef struct packed {
      logic                    draw_line;
      logic signed [POS_W-1:0] start_x;
      logic signed [POS_W-1:0] start_y;
      logic signed [POS_W-1:0] end_x;
      logic signed [POS_W-1:0] end_y;
      logic [HEADING_W-1:0]    heading_deg;
   } tvs_rsp_type;

   // Unsigned Q0.15 sine of 0..90 degrees
   function automatic logic [14:0] sine_quarter(input logic [6:0] d);
      logic [14:0] v;
      case (d)
         7'd0: v = 15'd0;         7'd1: v = 15'd572;       7'd2: v = 15'd1144;
         7'd3: v = 15'd1715;      7'd4: v = 15'd2286;      7'd5: v = 15'd2856;
         7'd6: v = 15'd3425;      7'd7: v = 15'd3993;      7'd8: v = 15'd4560;
         7'd9: v = 15'd5126;      7'd10: v = 15'd5690;     7'd11: v = 15'd6252;
         7'd12: v = 15'd6813;     7'd13: v = 15'd7371;     7'd14: v = 15'd7927;
         7'd15: v = 15'd8481;     7'd16: v = 15'd9032;     7'd17: v = 15'd9580;
         7'd18: v = 15'd10126;    7'd19: v = 15'd10668;    7'd20: v = 15'd11207;
         7'd21: v = 15'd11743;    7'd22: v = 15'd12275;    7'd23: v = 15'd12803;
         7'd24: v = 15'd13328;    7'd25: v = 15'd13848;    7'd26: v = 15'd14365;
         7'd27: v = 15'd14876;    7'd28: v = 15'd15384;    7'd29: v = 15'd15886;
         7'd30: v = 15'd16384;    7'd31: v = 15'd16877;    7'd32: v = 15'd17364;
         7'd33: v = 15'd17847;    7'd34: v = 15'd18324;    7'd35: v = 15'd18795;
         7'd36: v = 15'd19261;    7'd37: v = 15'd19720;    7'd38: v = 15'd20174;
         7'd39: v = 15'd20622;    7'd40: v = 15'd21063;    7'd41: v = 15'd21498;
         7'd42: v = 15'd21926;    7'd43: v = 15'd22348;    7'd44: v = 15'd22763;
         7'd45: v = 15'd23170;    7'd46: v = 15'd23571;    7'd47: v = 15'd23965;
         7'd48: v = 15'd24351;    7'd49: v = 15'd24730;    7'd50: v = 15'd25102;
         7'd51: v = 15'd25466;    7'd52: v = 15'd25822;    7'd53: v = 15'd26170;
         7'd54: v = 15'd26510;    7'd55: v = 15'd26842;    7'd56: v = 15'd27166;
         7'd57: v = 15'd27482;    7'd58: v = 15'd27789;    7'd59: v = 15'd28088;
         7'd60: v = 15'd28378;    7'd61: v = 15'd28660;    7'd62: v = 15'd28932;
         7'd63: v = 15'd29197;    7'd64: v = 15'd29452;    7'd65: v = 15'd29698;
         7'd66: v = 15'd29935;    7'd67: v = 15'd30163;    7'd68: v = 15'd30382;
         7'd69: v = 15'd30592;    7'd70: v = 15'd30792;    7'd71: v = 15'd30983;
         7'd72: v = 15'd31164;    7'd73: v = 15'd31336;    7'd74: v = 15'd31499;
         7'd75: v = 15'd31651;    7'd76: v = 15'd31795;    7'd77: v = 15'd31928;
         7'd78: v = 15'd32052;    7'd79: v = 15'd32166;    7'd80: v = 15'd32270;
         7'd81: v = 15'd32365;    7'd82: v = 15'd32449;    7'd83: v = 15'd32524;
         7'd84: v = 15'd32588;    7'd85: v = 15'd32643;    7'd86: v = 15'd32688;
         7'd87: v = 15'd32723;    7'd88: v = 15'd32748;    7'd89: v = 15'd32763;
         7'd90: v = 15'd32767;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [SINE_W-1:0] sine_deg(input logic [HEADING_W-1:0] h);
      logic [HEADING_W-1:0]    idx;
      logic signed [SINE_W-1:0] mag;
      logic                     neg;
      if (h <= QUARTER_TURN) begin
         idx = h;
         neg = 1'b0;
      end else if (h <= HALF_TURN) begin
         idx = HALF_TURN - h;
         neg = 1'b0;
      end else if (h <= THREE_QUARTER) begin
         idx = h - HALF_TURN;
         neg = 1'b1;
      end else begin
         idx = HEADING_W'(FULL_TURN - {1'b0, h});
         neg = 1'b1;
      end
      mag = $signed({2'b00, sine_quarter(idx[6:0])});
      return neg ? -mag : mag;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > WIDE_MAX) begin
         r = POS_MAX;
      end else if (v < WIDE_MIN) begin
         r = POS_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] home_pos(input logic [HOME_W-1:0] h,
                                                       input int unsigned frac);
      logic [26:0] w;
      logic signed [POS_W-1:0] r;
      w = 27'(h) << frac;
      if (w > 27'(POS_MAX)) begin
         r = POS_MAX;
      end else begin
         r = $signed(w[POS_W-1:0]);
      end
      return r;
   endfunction

endpackage

[rtl/core/tvs_turn.sv]
// Heading update: heading plus signed degrees, wrapped into 0..359.
module tvs_turn
   import tvs_pkg::*;
(
   input  logic [HEADING_W-1:0]        heading,
   input  logic signed [AMOUNT_W-1:0]  amount,
   output logic [HEADING_W-1:0]        heading_next
);

   localparam int unsigned OFFSET     = 33120;
   localparam int unsigned RECIP      = 1456;
   localparam int unsigned RECIP_BITS = 19;

   logic signed [17:0] sum;
   logic [16:0]        shifted;
   logic [27:0]        prod;
   logic [7:0]         quot;
   logic [17:0]        rem_wide;
   logic [9:0]         rem;

   always_comb begin
      sum      = 18'(amount) + $signed({9'd0, heading});
      shifted  = 17'(sum + 18'(OFFSET));
      prod     = 28'(shifted) * 28'(RECIP);
      quot     = 8'(prod >> RECIP_BITS);
      rem_wide = 18'(shifted) - 18'(quot) * 18'(FULL_TURN);
      rem      = rem_wide[9:0];
      if (rem >= FULL_TURN) begin
         rem = rem - FULL_TURN;
      end
      heading_next = rem[HEADING_W-1:0];
   end

endmodule

[rtl/core/tvs_move.sv]
// Move datapath: trig lookup, scaled step products and saturating add.
module tvs_move
   import tvs_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 8
)
(
   input  logic [HEADING_W-1:0]       heading,
   input  logic signed [AMOUNT_W-1:0] amount,
   input  logic signed [POS_W-1:0]    pos_x,
   input  logic signed [POS_W-1:0]    pos_y,
   output logic signed [POS_W-1:0]    end_x,
   output logic signed [POS_W-1:0]    end_y
);

   localparam int SHIFT = 15 - int'(FRACTION_BITS);
   localparam int unsigned RSH = (SHIFT > 0) ? SHIFT : 0;
   localparam int unsigned LSH = (SHIFT > 0) ? 0 : -SHIFT;
   localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'((64'd1 << RSH) >> 1);

   logic [HEADING_W-1:0]      cos_idx;
   logic signed [SINE_W-1:0]  sin_v;
   logic signed [SINE_W-1:0]  cos_v;
   logic signed [32:0]        prod_x;
   logic signed [32:0]        prod_y;
   logic signed [WIDE_W-1:0]  dx;
   logic signed [WIDE_W-1:0]  dy;

   always_comb begin
      cos_idx = (heading >= THREE_QUARTER) ? heading - THREE_QUARTER
                                           : heading + QUARTER_TURN;
      sin_v   = sine_deg(heading);
      cos_v   = sine_deg(cos_idx);
      prod_x  = amount * cos_v;
      prod_y  = amount * sin_v;
      dx      = ((WIDE_W'(prod_x) + HALF) >>> RSH) <<< LSH;
      dy      = ((WIDE_W'(prod_y) + HALF) >>> RSH) <<< LSH;
      end_x   = sat_pos(WIDE_W'(pos_x) + dx);
      end_y   = sat_pos(WIDE_W'(pos_y) - dy);
   end

endmodule

[rtl/core/turtle_vector_stepper_unit.sv]
// Top level of the turtle vector stepper: word registers, turtle state, control.
//
// Input words (req_) carry one command: move, turn, home or set pen. Each
// accepted word yields exactly one result word (rsp_) describing the segment
// from the old to the new position, with draw_line set for move or home while
// the pen is down, plus the heading after the command.
// A word is taken when valid is high and stall is low on the same edge.
// A taken word waits in the input register, then its result word is held in the
// result register until it is taken. Throughput: one word per cycle while the
// receiver does not stall, set by the combinational trig lookup, multiply and
// saturating add that update position and heading from the input register.
// When the receiver stalls, the result word holds; one more word is taken into
// the input register, after which req_stall rises.
// Reset (synchronous, active high) empties both registers and puts the turtle
// at home (160, 90), heading 90, pen down. csr_ writes set the home point and
// take effect at the next home command.
module turtle_vector_stepper_unit
   import tvs_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 8
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tvs_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tvs_rsp_type       rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [HOME_W-1:0] csr_write_data
);

   logic                    in_valid_ff, in_valid_in;
   tvs_req_type             in_data_ff, in_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tvs_rsp_type             rsp_data_ff, rsp_data_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0] pos_y_ff, pos_y_in;
   logic [HEADING_W-1:0]    heading_ff, heading_in;
   logic                    pen_ff, pen_in;
   logic [HOME_W-1:0]       home_x_ff, home_x_in;
   logic [HOME_W-1:0]       home_y_ff, home_y_in;

   logic                    advance;
   logic [HEADING_W-1:0]    turn_heading;
   logic signed [POS_W-1:0] move_x;
   logic signed [POS_W-1:0] move_y;

   tvs_turn u_turn (
      .heading      (heading_ff),
      .amount       (in_data_ff.amount),
      .heading_next (turn_heading)
   );

   tvs_move #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_move (
      .heading (heading_ff),
      .amount  (in_data_ff.amount),
      .pos_x   (pos_x_ff),
      .pos_y   (pos_y_ff),
      .end_x   (move_x),
      .end_y   (move_y)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      home_x_in = home_x_ff;
      home_y_in = home_y_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HOME_X: home_x_in = csr_write_data;
            CSR_HOME_Y: home_y_in = csr_write_data;
            default:    home_x_in = home_x_ff;
         endcase
      end
   end

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      heading_in = heading_ff;
      pen_in     = pen_ff;
      rsp_data_in.draw_line = 1'b0;
      case (in_data_ff.operation)
         OP_MOVE: begin
            pos_x_in = move_x;
            pos_y_in = move_y;
            rsp_data_in.draw_line = pen_ff;
         end
         OP_TURN: begin
            heading_in = turn_heading;
         end
         OP_HOME: begin
            pos_x_in   = home_pos(home_x_ff, FRACTION_BITS);
            pos_y_in   = home_pos(home_y_ff, FRACTION_BITS);
            heading_in = HOME_HEADING;
            rsp_data_in.draw_line = pen_ff;
         end
         OP_PEN: begin
            pen_in = in_data_ff.pen_down;
         end
         default: begin
            pen_in = pen_ff;
         end
      endcase
      rsp_data_in.start_x     = pos_x_ff;
      rsp_data_in.start_y     = pos_y_ff;
      rsp_data_in.end_x       = pos_x_in;
      rsp_data_in.end_y       = pos_y_in;
      rsp_data_in.heading_deg = heading_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= home_pos(HOME_X_RESET, FRACTION_BITS);
         pos_y_ff     <= home_pos(HOME_Y_RESET, FRACTION_BITS);
         heading_ff   <= HOME_HEADING;
         pen_ff       <= 1'b1;
         home_x_ff    <= HOME_X_RESET;
         home_y_ff    <= HOME_Y_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         home_x_ff    <= home_x_in;
         home_y_ff    <= home_y_in;
         if (advance) begin
            pos_x_ff   <= pos_x_in;
            pos_y_ff   <= pos_y_in;
            heading_ff <= heading_in;
            pen_ff     <= pen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
